[rtl/core/sdrd_pkg.sv]
// ----------------------------------------------------------------------------
// sdrd_pkg: shared types, constants and CRC helpers
// Phase encoding, status codes, register map and the result record for the
// SD-card SPI single-block read engine.
// ----------------------------------------------------------------------------
package sdrd_pkg;

   localparam int BLOCK_BYTES = 512;
   localparam int TRAIL_BYTES = 8;

   localparam logic [7:0] CMD17_BYTE   = 8'h51;
   localparam logic [7:0] IDLE_BYTE    = 8'hFF;
   localparam logic [7:0] DATA_TOKEN   = 8'hFE;
   localparam logic [7:0] CRC7_POLY    = 8'h89;
   localparam logic [15:0] CRC16_POLY  = 16'h1021;

   localparam logic [15:0] RESP_LIMIT_RESET  = 16'd1000;
   localparam logic [15:0] TOKEN_LIMIT_RESET = 16'd20000;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_BYTE  = 1'b1;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [1:0] {
      CSR_BLOCK_ADDRESSING = 2'd0,
      CSR_RESPONSE_LIMIT   = 2'd1,
      CSR_TOKEN_LIMIT      = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NORESP  = 3'd1,
      ST_CARDERR = 3'd2,
      ST_TOKEN   = 3'd3,
      ST_CRC     = 3'd4
   } status_type;

   typedef enum logic [6:0] {
      PH_IDLE  = 7'b0000001,
      PH_CMD   = 7'b0000010,
      PH_R1    = 7'b0000100,
      PH_TOKEN = 7'b0001000,
      PH_DATA  = 7'b0010000,
      PH_CRC   = 7'b0100000,
      PH_TRAIL = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic        block_addressing;
      logic [15:0] response_poll_limit;
      logic [15:0] token_poll_limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       chip_select;
      logic       data_valid;
      logic [7:0] data_byte;
      logic       done_res;
      logic [2:0] status;
      logic [7:0] response_value;
   } rsp_type;

   function automatic logic [7:0] crc7_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (r[7]) begin
            r = r ^ CRC7_POLY;
         end
         r = {r[6:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] r;
      r = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ CRC16_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

[rtl/core/sdrd_csr.sv]
// ----------------------------------------------------------------------------
// sdrd_csr: configuration registers
// APB-style register file holding the addressing mode and the two poll limits.
// ----------------------------------------------------------------------------
module sdrd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sdrd_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [sdrd_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [sdrd_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   output sdrd_pkg::cfg_type                   cfg
);

   logic        block_addr_ff;
   logic [15:0] resp_limit_ff;
   logic [15:0] token_limit_ff;
   logic        wr_en;
   logic [1:0]  index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         block_addr_ff  <= 1'b0;
         resp_limit_ff  <= sdrd_pkg::RESP_LIMIT_RESET;
         token_limit_ff <= sdrd_pkg::TOKEN_LIMIT_RESET;
      end else if (wr_en) begin
         case (index)
            sdrd_pkg::CSR_BLOCK_ADDRESSING: block_addr_ff  <= pwdata[0];
            sdrd_pkg::CSR_RESPONSE_LIMIT:   resp_limit_ff  <= pwdata[15:0];
            sdrd_pkg::CSR_TOKEN_LIMIT:      token_limit_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         sdrd_pkg::CSR_BLOCK_ADDRESSING: prdata = {31'd0, block_addr_ff};
         sdrd_pkg::CSR_RESPONSE_LIMIT:   prdata = {16'd0, resp_limit_ff};
         sdrd_pkg::CSR_TOKEN_LIMIT:      prdata = {16'd0, token_limit_ff};
         default:                        prdata = '0;
      endcase
   end

   assign cfg.block_addressing    = block_addr_ff;
   assign cfg.response_poll_limit = resp_limit_ff;
   assign cfg.token_poll_limit    = token_limit_ff;

endmodule

[rtl/core/sdrd_engine.sv]
// ----------------------------------------------------------------------------
// sdrd_engine: read sequencer
// Holds the read state; each accepted exchange gives one result unless no read is running.
// ----------------------------------------------------------------------------
module sdrd_engine (
   input  logic              clock,
   input  logic              reset,
   input  sdrd_pkg::cfg_type cfg,
   input  logic              accept,
   input  logic              action,
   input  logic [31:0]       sector_address,
   input  logic [7:0]        rx_byte,
   output logic              res_valid,
   output sdrd_pkg::rsp_type res
);

   sdrd_pkg::phase_type phase_ff, phase_in;
   logic [15:0]         step_ff, step_in;
   logic [7:0]          cmd_crc_ff, cmd_crc_in;
   logic [15:0]         data_crc_ff, data_crc_in;
   logic [31:0]         arg_ff, arg_in;
   logic [7:0]          crc_high_ff, crc_high_in;
   logic [7:0]          resp_seen_ff, resp_seen_in;
   logic [2:0]          result_ff, result_in;

   logic [15:0] step_inc;
   logic [7:0]  arg_byte;
   logic [15:0] crc16_next;
   logic        produce;
   logic [7:0]  tx;
   logic        cs;
   logic        dv;
   logic [7:0]  db;
   logic        done;

   assign step_inc   = step_ff + 16'd1;
   assign crc16_next = sdrd_pkg::crc16_byte(data_crc_ff, rx_byte);

   always_comb begin
      case (step_ff[1:0])
         2'd0:    arg_byte = arg_ff[31:24];
         2'd1:    arg_byte = arg_ff[23:16];
         2'd2:    arg_byte = arg_ff[15:8];
         default: arg_byte = arg_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      cmd_crc_in   = cmd_crc_ff;
      data_crc_in  = data_crc_ff;
      arg_in       = arg_ff;
      crc_high_in  = crc_high_ff;
      resp_seen_in = resp_seen_ff;
      result_in    = result_ff;
      produce      = 1'b1;
      tx           = sdrd_pkg::IDLE_BYTE;
      cs           = 1'b1;
      dv           = 1'b0;
      db           = 8'd0;
      done         = 1'b0;

      if (!action) begin
         // start: abandon anything running
         arg_in       = cfg.block_addressing ? sector_address : {sector_address[22:0], 9'd0};
         cmd_crc_in   = sdrd_pkg::crc7_byte(8'd0, sdrd_pkg::CMD17_BYTE);
         data_crc_in  = 16'd0;
         crc_high_in  = 8'd0;
         resp_seen_in = sdrd_pkg::IDLE_BYTE;
         result_in    = sdrd_pkg::ST_OK;
         phase_in     = sdrd_pkg::PH_CMD;
         step_in      = 16'd0;
         tx           = sdrd_pkg::CMD17_BYTE;
      end else begin
         case (phase_ff)
            sdrd_pkg::PH_CMD: begin
               if (step_ff < 16'd4) begin
                  cmd_crc_in = sdrd_pkg::crc7_byte(cmd_crc_ff, arg_byte);
                  step_in    = step_inc;
                  tx         = arg_byte;
               end else if (step_ff == 16'd4) begin
                  step_in = 16'd5;
                  tx      = cmd_crc_ff | 8'h01;
               end else begin
                  phase_in = sdrd_pkg::PH_R1;
                  step_in  = 16'd0;
               end
            end
            sdrd_pkg::PH_R1: begin
               step_in = step_inc;
               if (!rx_byte[7]) begin
                  resp_seen_in = rx_byte;
                  if (rx_byte[6:1] != 6'd0) begin
                     result_in = sdrd_pkg::ST_CARDERR;
                     phase_in  = sdrd_pkg::PH_IDLE;
                     step_in   = 16'd0;
                     cs        = 1'b0;
                     done      = 1'b1;
                  end else begin
                     phase_in = sdrd_pkg::PH_TOKEN;
                     step_in  = 16'd0;
                  end
               end else if (step_inc >= cfg.response_poll_limit) begin
                  result_in = sdrd_pkg::ST_NORESP;
                  phase_in  = sdrd_pkg::PH_IDLE;
                  step_in   = 16'd0;
                  cs        = 1'b0;
                  done      = 1'b1;
               end
            end
            sdrd_pkg::PH_TOKEN: begin
               step_in = step_inc;
               if (rx_byte == sdrd_pkg::DATA_TOKEN) begin
                  phase_in    = sdrd_pkg::PH_DATA;
                  step_in     = 16'd0;
                  data_crc_in = 16'd0;
               end else if (step_inc >= cfg.token_poll_limit) begin
                  result_in = sdrd_pkg::ST_TOKEN;
                  step_in   = 16'd0;
                  if (sdrd_pkg::TRAIL_BYTES == 0) begin
                     phase_in = sdrd_pkg::PH_IDLE;
                     cs       = 1'b0;
                     done     = 1'b1;
                  end else begin
                     phase_in = sdrd_pkg::PH_TRAIL;
                  end
               end
            end
            sdrd_pkg::PH_DATA: begin
               data_crc_in = crc16_next;
               step_in     = step_inc;
               if (step_inc >= 16'(sdrd_pkg::BLOCK_BYTES)) begin
                  phase_in = sdrd_pkg::PH_CRC;
                  step_in  = 16'd0;
               end
               dv = 1'b1;
               db = rx_byte;
            end
            sdrd_pkg::PH_CRC: begin
               if (step_ff == 16'd0) begin
                  crc_high_in = rx_byte;
                  step_in     = 16'd1;
               end else begin
                  result_in = ({crc_high_ff, rx_byte} == data_crc_ff) ?
                              sdrd_pkg::ST_OK : sdrd_pkg::ST_CRC;
                  step_in   = 16'd0;
                  if (sdrd_pkg::TRAIL_BYTES == 0) begin
                     phase_in = sdrd_pkg::PH_IDLE;
                     cs       = 1'b0;
                     done     = 1'b1;
                  end else begin
                     phase_in = sdrd_pkg::PH_TRAIL;
                  end
               end
            end
            sdrd_pkg::PH_TRAIL: begin
               step_in = step_inc;
               if (step_inc >= 16'(sdrd_pkg::TRAIL_BYTES)) begin
                  phase_in = sdrd_pkg::PH_IDLE;
                  step_in  = 16'd0;
                  cs       = 1'b0;
                  done     = 1'b1;
               end
            end
            default: begin
               // received byte while idle: drop it
               produce = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sdrd_pkg::PH_IDLE;
         step_ff      <= 16'd0;
         cmd_crc_ff   <= 8'd0;
         data_crc_ff  <= 16'd0;
         arg_ff       <= 32'd0;
         crc_high_ff  <= 8'd0;
         resp_seen_ff <= sdrd_pkg::IDLE_BYTE;
         result_ff    <= sdrd_pkg::ST_OK;
      end else if (accept) begin
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         cmd_crc_ff   <= cmd_crc_in;
         data_crc_ff  <= data_crc_in;
         arg_ff       <= arg_in;
         crc_high_ff  <= crc_high_in;
         resp_seen_ff <= resp_seen_in;
         result_ff    <= result_in;
      end
   end

   assign res_valid          = accept && produce;
   assign res.tx_byte        = tx;
   assign res.chip_select    = cs;
   assign res.data_valid     = dv;
   assign res.data_byte      = db;
   assign res.done_res       = done;
   assign res.status         = result_in;
   assign res.response_value = resp_seen_in;

endmodule

[rtl/core/sdrd_out_buf.sv]
// ----------------------------------------------------------------------------
// sdrd_out_buf: result register with skid stage
// Two-entry output buffer so the input side stalls only from a register.
// ----------------------------------------------------------------------------
module sdrd_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sdrd_pkg::rsp_type push_data,
   output logic              full,
   output logic              out_valid,
   input  logic              out_stall,
   output sdrd_pkg::rsp_type out_data
);

   logic              main_valid_ff;
   logic              skid_valid_ff;
   sdrd_pkg::rsp_type main_ff;
   sdrd_pkg::rsp_type skid_ff;
   logic              pop;

   assign pop = main_valid_ff && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_ff <= push_data;
         end else begin
            main_ff <= push_data;
         end
      end
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

[rtl/core/sd_spi_block_read_engine_unit.sv]
// ----------------------------------------------------------------------------
// sd_spi_block_read_engine_unit: SD-card SPI single-block read engine
// Sequences one CMD17 read, one SPI byte exchange per transaction.
// ----------------------------------------------------------------------------
// Usage: send a req_ transaction with req_action low and req_sector_address
// to start a read. Each rsp_ transaction gives the byte to shift out next
// and the chip-select level; feed the byte shifted in back as a req_
// transaction with req_action high. rsp_done_res marks the last response,
// carrying rsp_status and rsp_response_value. A byte sent while no read is
// running produces no response. Block bytes appear with rsp_data_valid.
// The response is registered in the output buffer once the request is accepted.
// Throughput: one transaction per cycle while req_stall is low; the sequencer state updates at
// accept, so consecutive bytes of a read can follow in back-to-back cycles.
// A two-entry output buffer absorbs a stall on rsp_; req_stall rises only
// once both entries are full. Reset (synchronous) empties the buffer,
// returns the sequencer to idle and restores the register defaults.
// Registers on psel/penable/paddr: 0x0 addressing mode, 0x4 response poll
// limit, 0x8 token poll limit.
// ----------------------------------------------------------------------------
module sd_spi_block_read_engine_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [31:0]                         req_sector_address,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_tx_byte,
   output logic                                rsp_chip_select,
   output logic                                rsp_data_valid,
   output logic [7:0]                          rsp_data_byte,
   output logic                                rsp_done_res,
   output logic [2:0]                          rsp_status,
   output logic [7:0]                          rsp_response_value,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sdrd_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [sdrd_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [sdrd_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);

   sdrd_pkg::cfg_type cfg;
   sdrd_pkg::rsp_type res;
   sdrd_pkg::rsp_type out_data;
   logic              res_valid;
   logic              full;
   logic              accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   sdrd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sdrd_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .accept         (accept),
      .action         (req_action),
      .sector_address (req_sector_address),
      .rx_byte        (req_rx_byte),
      .res_valid      (res_valid),
      .res            (res)
   );

   sdrd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_tx_byte        = out_data.tx_byte;
   assign rsp_chip_select    = out_data.chip_select;
   assign rsp_data_valid     = out_data.data_valid;
   assign rsp_data_byte      = out_data.data_byte;
   assign rsp_done_res       = out_data.done_res;
   assign rsp_status         = out_data.status;
   assign rsp_response_value = out_data.response_value;

endmodule

[rtl/core/sdrd_checker.sv]
// ----------------------------------------------------------------------------
// sdrd_checker: port-level assertions
// Checks response framing rules seen on the top-level ports.
// ----------------------------------------------------------------------------
module sdrd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_chip_select,
   input logic       rsp_data_valid,
   input logic       rsp_done_res,
   input logic [2:0] rsp_status
);

   // reset empties the output buffer
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx_byte))
      else $error("stalled response changed");

   a_done_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_chip_select && rsp_tx_byte == 8'hFF)
      else $error("last response does not release the card");

   a_release_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_chip_select |-> rsp_done_res)
      else $error("chip select released before the last response");

   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_valid |-> rsp_chip_select && rsp_status == sdrd_pkg::ST_OK &&
      !rsp_done_res)
      else $error("block byte outside a healthy transfer");

endmodule

bind sd_spi_block_read_engine_unit sdrd_checker u_sdrd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_tx_byte     (rsp_tx_byte),
   .rsp_chip_select (rsp_chip_select),
   .rsp_data_valid  (rsp_data_valid),
   .rsp_done_res    (rsp_done_res),
   .rsp_status      (rsp_status)
);
